// ===== rtl/fdb_pkg.sv =====
// Shared types and constants for the 17-tap decimate-by-two FIR.
// Used by fdb_cell, fdb_sum_tree and fir_decimate_by_two; depends on nothing.
package fdb_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int HALF_TAPS   = 8;
   localparam int NUM_TAPS    = 2 * HALF_TAPS + 1;
   localparam int COEF_W      = 20;
   localparam int PROD_W      = COEF_W + SAMPLE_W + 1;
   localparam int ACC_W       = 40;

   localparam int TAP_REGS     = 6;
   localparam int TAPS_PER_REG = 3;
   localparam int CSR_DATA_W   = TAPS_PER_REG * COEF_W;
   localparam int TAP_LAST_W   = 2 * COEF_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int SHIFT_W      = 5;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;

   // Leaves of the sum tree: one product per tap plus the rounding offset.
   localparam int LEAVES      = NUM_TAPS + 1;
   localparam int L1_N        = 9;
   localparam int L2_N        = 5;
   localparam int L3_N        = 3;
   localparam int TREE_LEVELS = 5;
   // Window stage, product stage, then one stage per tree level.
   localparam int PIPE_DEPTH  = 2 + TREE_LEVELS;

   localparam int SEEN_W      = 4;
   localparam int FLUSH_CNT_W = 3;
   localparam logic EMIT_PARITY = 1'(HALF_TAPS % 2);

   localparam int FIFO_DEPTH  = 16;
   localparam int FIFO_PTR_W  = 4;
   localparam int FIFO_CNT_W  = 5;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TAPS_0_TO_2   = 3'd0,
      CSR_TAPS_3_TO_5   = 3'd1,
      CSR_TAPS_6_TO_8   = 3'd2,
      CSR_TAPS_9_TO_11  = 3'd3,
      CSR_TAPS_12_TO_14 = 3'd4,
      CSR_TAPS_15_TO_16 = 3'd5,
      CSR_SHIFT_BITS    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic load;   // take the broadcast sample (start of line)
      logic shift;  // take the neighbor's sample
   } cell_ctrl_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   typedef struct packed {
      logic                last;
      logic [SAMPLE_W-1:0] sample;
   } out_entry_type;

endpackage

// ===== rtl/fdb_cell.sv =====
// One window cell: holds a sample, passes it on, and forms its tap product.
// Depends on fdb_pkg.
module fdb_cell (
   input  logic                                 clock,
   input  fdb_pkg::cell_ctrl_type               ctrl,
   input  logic [fdb_pkg::SAMPLE_W-1:0]         load_sample,
   input  logic [fdb_pkg::SAMPLE_W-1:0]         near_sample,
   input  logic signed [fdb_pkg::COEF_W-1:0]    coef,
   output logic [fdb_pkg::SAMPLE_W-1:0]         sample,
   output logic signed [fdb_pkg::PROD_W-1:0]    product
);

   logic [fdb_pkg::SAMPLE_W-1:0]      sample_ff;
   logic signed [fdb_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      priority if (ctrl.load) begin
         sample_ff <= load_sample;
      end else if (ctrl.shift) begin
         sample_ff <= near_sample;
      end else begin
         sample_ff <= sample_ff;   // hold while the window is stalled
      end
      product_ff <= $signed({1'b0, sample_ff}) * coef;
   end

   assign sample  = sample_ff;
   assign product = product_ff;

endmodule

// ===== rtl/fdb_sum_tree.sv =====
// Registered adder tree, five levels, over the tap products and offset.
// Depends on fdb_pkg.
module fdb_sum_tree (
   input  logic                              clock,
   input  logic signed [fdb_pkg::ACC_W-1:0]  leaf [fdb_pkg::LEAVES],
   output logic signed [fdb_pkg::ACC_W-1:0]  sum
);

   logic signed [fdb_pkg::ACC_W-1:0] l1_ff [fdb_pkg::L1_N];
   logic signed [fdb_pkg::ACC_W-1:0] l2_ff [fdb_pkg::L2_N];
   logic signed [fdb_pkg::ACC_W-1:0] l3_ff [fdb_pkg::L3_N];
   logic signed [fdb_pkg::ACC_W-1:0] l4_ff [2];
   logic signed [fdb_pkg::ACC_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < fdb_pkg::L1_N; i++) begin
         l1_ff[i] <= leaf[2*i] + leaf[2*i+1];
      end
      // odd counts: carry the last element up unchanged
      for (int i = 0; i < fdb_pkg::L2_N - 1; i++) begin
         l2_ff[i] <= l1_ff[2*i] + l1_ff[2*i+1];
      end
      l2_ff[fdb_pkg::L2_N-1] <= l1_ff[fdb_pkg::L1_N-1];
      for (int i = 0; i < fdb_pkg::L3_N - 1; i++) begin
         l3_ff[i] <= l2_ff[2*i] + l2_ff[2*i+1];
      end
      l3_ff[fdb_pkg::L3_N-1] <= l2_ff[fdb_pkg::L2_N-1];
      l4_ff[0] <= l3_ff[0] + l3_ff[1];
      l4_ff[1] <= l3_ff[2];
      sum_ff   <= l4_ff[0] + l4_ff[1];
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/fir_decimate_by_two.sv =====
// A result goes from the window step that completes it (the accepted request, or one of the flush
// steps after a line_end) through the product and tree registers into the queue behind rsp_tvalid.
// Throughput: one request per cycle unless held; a line_end adds eight flush steps with
// req_tready low, set by the flush sequencer pushing the edge sample through the window cells.
// Requests that emit a result also hold while sixteen are queued or in flight (queue credits).
// Reset (synchronous): line restarts, queue empties, taps clear to zero, shift_bits to 16.
module fir_decimate_by_two (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] sample
   input  logic                                  req_tlast,   // line_end
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,   // [7:0] out_sample
   output logic                                  rsp_tlast,   // out_last
   // configuration writes
   input  logic                                  csr_wr_en,
   input  logic [fdb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [fdb_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [fdb_pkg::CSR_DATA_W-1:0] taps_ff [fdb_pkg::TAP_REGS];
   logic [fdb_pkg::SHIFT_W-1:0]    shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < fdb_pkg::TAP_REGS; r++) begin
            taps_ff[r] <= '0;
         end
         shift_ff <= fdb_pkg::SHIFT_RESET;
      end else if (csr_wr_en) begin
         unique case (fdb_pkg::csr_index_type'(csr_index))
            fdb_pkg::CSR_TAPS_0_TO_2:   taps_ff[0] <= csr_wdata;
            fdb_pkg::CSR_TAPS_3_TO_5:   taps_ff[1] <= csr_wdata;
            fdb_pkg::CSR_TAPS_6_TO_8:   taps_ff[2] <= csr_wdata;
            fdb_pkg::CSR_TAPS_9_TO_11:  taps_ff[3] <= csr_wdata;
            fdb_pkg::CSR_TAPS_12_TO_14: taps_ff[4] <= csr_wdata;
            fdb_pkg::CSR_TAPS_15_TO_16: begin
               taps_ff[5] <= fdb_pkg::CSR_DATA_W'(csr_wdata[fdb_pkg::TAP_LAST_W-1:0]);
            end
            fdb_pkg::CSR_SHIFT_BITS:    shift_ff <= csr_wdata[fdb_pkg::SHIFT_W-1:0];
            default: ;  // index beyond the register list: drop the write
         endcase
      end
   end

   // Unpack tap j from register j/3, slot j%3 (all constant selects).
   logic signed [fdb_pkg::COEF_W-1:0] coef [fdb_pkg::NUM_TAPS];

   for (genvar j = 0; j < fdb_pkg::NUM_TAPS; j++) begin : g_coef
      assign coef[j] = $signed(taps_ff[j / fdb_pkg::TAPS_PER_REG]
                       [(j % fdb_pkg::TAPS_PER_REG) * fdb_pkg::COEF_W +: fdb_pkg::COEF_W]);
   end

   // ---------------------------------------------------------------
   // Line sequencer: one window step per accepted request, plus
   // HALF_TAPS flush steps after line_end that repeat the edge sample.
   // ---------------------------------------------------------------
   logic                             start_ff,    start_in;
   logic                             flushing_ff, flushing_in;
   logic [fdb_pkg::FLUSH_CNT_W-1:0]  flush_cnt_ff, flush_cnt_in;
   logic [fdb_pkg::SEEN_W-1:0]       seen_ff,     seen_in;
   logic                             odd_ff,      odd_in;
   logic [fdb_pkg::FIFO_CNT_W-1:0]   credit_ff,   credit_in;

   logic [fdb_pkg::SEEN_W-1:0]       seen_step;
   logic                             shift_emit;
   logic                             credit_ok;
   logic                             step;
   logic                             issue;
   logic                             issue_last;
   fdb_pkg::cell_ctrl_type           cell_ctrl;
   logic                             pop;

   assign credit_ok  = credit_ff < fdb_pkg::FIFO_CNT_W'(fdb_pkg::FIFO_DEPTH);
   assign seen_step  = (seen_ff == fdb_pkg::SEEN_W'(fdb_pkg::HALF_TAPS)) ?
                       seen_ff : seen_ff + 1'b1;
   // a shift step lands on an output position once the left half is filled
   assign shift_emit = (seen_step == fdb_pkg::SEEN_W'(fdb_pkg::HALF_TAPS)) &&
                       ((~odd_ff) == fdb_pkg::EMIT_PARITY);

   always_comb begin
      start_in     = start_ff;
      flushing_in  = flushing_ff;
      flush_cnt_in = flush_cnt_ff;
      seen_in      = seen_ff;
      odd_in       = odd_ff;
      cell_ctrl    = '0;
      req_tready   = 1'b0;
      step         = 1'b0;
      issue        = 1'b0;
      issue_last   = 1'b0;

      priority if (flushing_ff) begin
         // advance the flush unless an output needs a queue slot that is not there
         step = !shift_emit || credit_ok;
         if (step) begin
            cell_ctrl.shift = 1'b1;
            issue           = shift_emit;
            // final output of the line comes from one of the last two flush steps
            issue_last      = shift_emit &&
                              (flush_cnt_ff >= fdb_pkg::FLUSH_CNT_W'(fdb_pkg::HALF_TAPS - 2));
            seen_in         = seen_step;
            odd_in          = ~odd_ff;
            flush_cnt_in    = flush_cnt_ff + 1'b1;
            if (flush_cnt_ff == fdb_pkg::FLUSH_CNT_W'(fdb_pkg::HALF_TAPS - 1)) begin
               flushing_in = 1'b0;
               start_in    = 1'b1;
               seen_in     = '0;
               odd_in      = 1'b0;
            end
         end
      end else if (start_ff) begin
         // first sample of a line fills the whole window; never an output
         req_tready = 1'b1;
         step       = req_tvalid;
         if (step) begin
            cell_ctrl.load = 1'b1;
            start_in       = 1'b0;
            seen_in        = '0;
            odd_in         = 1'b0;
         end
      end else begin
         req_tready = !shift_emit || credit_ok;
         step       = req_tvalid && req_tready;
         if (step) begin
            cell_ctrl.shift = 1'b1;
            issue           = shift_emit;
            seen_in         = seen_step;
            odd_in          = ~odd_ff;
         end
      end

      // line_end on an accepted request starts the flush
      if (!flushing_ff && step && req_tlast) begin
         flushing_in  = 1'b1;
         flush_cnt_in = '0;
      end
   end

   // Credits count queue slots held by queued or in-flight results.
   assign credit_in = credit_ff + fdb_pkg::FIFO_CNT_W'(issue) - fdb_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b1;
         flushing_ff  <= 1'b0;
         flush_cnt_ff <= '0;
         seen_ff      <= '0;
         odd_ff       <= 1'b0;
         credit_ff    <= '0;
      end else begin
         start_ff     <= start_in;
         flushing_ff  <= flushing_in;
         flush_cnt_ff <= flush_cnt_in;
         seen_ff      <= seen_in;
         odd_ff       <= odd_in;
         credit_ff    <= credit_in;
      end
   end

   // ---------------------------------------------------------------
   // Window: a row of cells, cell m holding x[i-m] for tap m-HALF_TAPS
   // ---------------------------------------------------------------
   logic [fdb_pkg::SAMPLE_W-1:0]      sample_row  [fdb_pkg::NUM_TAPS];
   logic signed [fdb_pkg::PROD_W-1:0] product_row [fdb_pkg::NUM_TAPS];
   logic [fdb_pkg::SAMPLE_W-1:0]      head_sample;

   // during flush the head cell repeats its own (edge) sample
   assign head_sample = flushing_ff ? sample_row[0] : req_tdata;

   for (genvar m = 0; m < fdb_pkg::NUM_TAPS; m++) begin : g_cell
      logic [fdb_pkg::SAMPLE_W-1:0] near_sample;

      if (m == 0) begin : g_head
         assign near_sample = head_sample;
      end else begin : g_body
         assign near_sample = sample_row[m-1];
      end

      fdb_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .load_sample (req_tdata),
         .near_sample (near_sample),
         .coef        (coef[m]),
         .sample      (sample_row[m]),
         .product     (product_row[m])
      );
   end

   // ---------------------------------------------------------------
   // Sum tree over the products plus the rounding offset
   // ---------------------------------------------------------------
   logic signed [fdb_pkg::ACC_W-1:0] leaf [fdb_pkg::LEAVES];
   logic signed [fdb_pkg::ACC_W-1:0] acc_sum;

   for (genvar m = 0; m < fdb_pkg::NUM_TAPS; m++) begin : g_leaf
      assign leaf[m] = {{(fdb_pkg::ACC_W - fdb_pkg::PROD_W){product_row[m][fdb_pkg::PROD_W-1]}},
                        product_row[m]};
   end

   // offset is half an output step; no offset when no shift is applied
   assign leaf[fdb_pkg::NUM_TAPS] = (shift_ff == '0) ? '0 :
                                    (fdb_pkg::ACC_W'(1) << (shift_ff - 1'b1));

   fdb_sum_tree u_sum_tree (
      .clock (clock),
      .leaf  (leaf),
      .sum   (acc_sum)
   );

   // Tags ride alongside the data path: window, product, tree levels.
   fdb_pkg::tag_type tag_ff [fdb_pkg::PIPE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < fdb_pkg::PIPE_DEPTH; s++) begin
            tag_ff[s] <= '0;
         end
      end else begin
         tag_ff[0].valid <= issue;
         tag_ff[0].last  <= issue_last;
         for (int s = 1; s < fdb_pkg::PIPE_DEPTH; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Round, clamp and queue the result
   // ---------------------------------------------------------------
   logic [fdb_pkg::ACC_W-1:0]    shifted;
   logic [fdb_pkg::SAMPLE_W-1:0] clamped;

   assign shifted = acc_sum >> shift_ff;

   always_comb begin
      priority if (acc_sum[fdb_pkg::ACC_W-1]) begin
         clamped = '0;
      end else if (|shifted[fdb_pkg::ACC_W-1:fdb_pkg::SAMPLE_W]) begin
         clamped = fdb_pkg::SAMPLE_MAX;
      end else begin
         clamped = shifted[fdb_pkg::SAMPLE_W-1:0];
      end
   end

   fdb_pkg::out_entry_type          queue_ff [fdb_pkg::FIFO_DEPTH];
   logic [fdb_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [fdb_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [fdb_pkg::FIFO_CNT_W-1:0]  count_ff,  count_in;
   logic                            push;

   assign push      = tag_ff[fdb_pkg::PIPE_DEPTH-1].valid;
   assign rsp_tvalid = count_ff != '0;
   assign pop       = rsp_tvalid && rsp_tready;
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + fdb_pkg::FIFO_CNT_W'(push) - fdb_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff].sample <= clamped;
         queue_ff[wr_ptr_ff].last   <= tag_ff[fdb_pkg::PIPE_DEPTH-1].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_tdata = queue_ff[rd_ptr_ff].sample;
   assign rsp_tlast = queue_ff[rd_ptr_ff].last;

endmodule
